/* rtl/trq_pkg.sv */
// Shared constants, cell layout and controller/datapath command types for the ticket ring queue.
`default_nettype none

package trq_pkg;

  // Ring geometry
  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned POS_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned SKIP_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(QUEUE_DEPTH - 1);
  localparam logic [SKIP_W-1:0] SKIP_LIMIT = SKIP_W'(QUEUE_DEPTH);

  // Field widths
  localparam int unsigned TICKET_W = 31;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned STAT_W   = 2;

  localparam logic [TICKET_W-1:0] TICKET_MAX      = '1;
  localparam logic [WORD_W-1:0]   EMPTY_WORD      = '1;
  localparam logic [LIMIT_W-1:0]  RETRY_LIMIT_RST = LIMIT_W'(10);

  // Request actions
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd3;

  // One ring cell; occ low stands for the empty owner
  typedef struct packed {
    logic                occ;
    logic [TICKET_W-1:0] owner;
    logic [TICKET_W-1:0] gap;
    logic [WORD_W-1:0]   word;
  } cell_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_GAP,
    WR_STORE,
    WR_EMPTY
  } wr_kind_e;

  typedef enum logic [1:0] {
    RD_TAIL_CUR,
    RD_TAIL_NEXT,
    RD_HEAD_CUR
  } rd_src_e;

  typedef enum logic [2:0] {
    RES_ENQ_DONE,
    RES_DEQ_WORD,
    RES_NONE,
    RES_FULL,
    RES_LIMIT
  } res_kind_e;

  // Controller to datapath
  typedef struct packed {
    wr_kind_e  wr_kind;
    logic      rd_en;
    rd_src_e   rd_src;
    logic      enq_start;
    logic      tail_inc;
    logic      skip_inc;
    logic      head_inc;
    logic      take_en;
    logic      take_first;
    logic      out_load;
    res_kind_e res_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic tail_sat;
    logic head_sat;
    logic skip_full;
    logic cell_occ;
    logic owner_match;
    logic gap_cover;
    logic first_limit;
    logic next_limit;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/trq_dp.sv */
// Datapath: cell memory, ticket counters, retry register and result register.
`default_nettype none

module trq_dp import trq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  input  logic [WORD_W-1:0]   in_value_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [WORD_W-1:0]   out_data_o,
  output logic [STAT_W-1:0]   out_status_o,
  output logic                out_got_o
);

  function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
    pos_next = (p == POS_LAST) ? '0 : p + 1'b1;
  endfunction

  cell_t mem_q [QUEUE_DEPTH];
  cell_t rd_q;
  cell_t wr_cell;

  logic [LIMIT_W-1:0]  limit_q;
  logic [TICKET_W-1:0] head_q, tail_q, ticket_q;
  logic [POS_W-1:0]    head_pos_q, tail_pos_q, clr_pos_q, addr_q;
  logic [LIMIT_W-1:0]  taken_q;
  logic [SKIP_W-1:0]   skip_q;
  logic [WORD_W-1:0]   value_q;

  logic                out_valid_q;
  logic [WORD_W-1:0]   out_data_q, out_data_d;
  logic [STAT_W-1:0]   out_status_q, out_status_d;
  logic                out_got_q, out_got_d;

  logic [POS_W-1:0]    rd_addr, wr_addr;
  logic                wr_en;
  logic [LIMIT_W:0]    taken_inc;

  // Select read address
  always_comb begin
    case (cmd_i.rd_src)
      RD_TAIL_CUR:  rd_addr = tail_pos_q;
      RD_TAIL_NEXT: rd_addr = pos_next(tail_pos_q);
      RD_HEAD_CUR:  rd_addr = head_pos_q;
      default:      rd_addr = tail_pos_q;
    endcase
  end

  // Build write data from the cell just read
  always_comb begin
    wr_cell = rd_q;
    wr_en   = 1'b1;
    wr_addr = addr_q;
    case (cmd_i.wr_kind)
      WR_CLEAR: begin
        wr_cell = '0;
        wr_addr = clr_pos_q;
      end
      WR_GAP: begin
        wr_cell.gap = tail_q;
      end
      WR_STORE: begin
        wr_cell.occ   = 1'b1;
        wr_cell.owner = tail_q;
        wr_cell.word  = value_q;
      end
      WR_EMPTY: begin
        wr_cell.occ = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Cell memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_cell;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Request payload and cell address
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_start) begin
      value_q <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      addr_q <= rd_addr;
    end
  end

  // Retry limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign taken_inc = {1'b0, taken_q} + (LIMIT_W + 1)'(1);

  // Advance tickets, positions and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      head_pos_q <= '0;
      tail_pos_q <= '0;
      clr_pos_q  <= '0;
      ticket_q   <= '0;
      taken_q    <= '0;
      skip_q     <= '0;
    end else begin
      if (cmd_i.wr_kind == WR_CLEAR) begin
        clr_pos_q <= pos_next(clr_pos_q);
      end
      if (cmd_i.tail_inc) begin
        tail_q     <= tail_q + 1'b1;
        tail_pos_q <= pos_next(tail_pos_q);
      end
      if (cmd_i.head_inc) begin
        head_q     <= head_q + 1'b1;
        head_pos_q <= pos_next(head_pos_q);
      end
      if (cmd_i.take_en) begin
        ticket_q <= head_q;
        taken_q  <= cmd_i.take_first ? LIMIT_W'(1) : taken_inc[LIMIT_W-1:0];
      end
      if (cmd_i.enq_start) begin
        skip_q <= '0;
      end else if (cmd_i.skip_inc) begin
        skip_q <= skip_q + 1'b1;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.clr_last    = (clr_pos_q == POS_LAST);
    stat_o.tail_sat    = (tail_q == TICKET_MAX);
    stat_o.head_sat    = (head_q == TICKET_MAX);
    stat_o.skip_full   = (skip_q == SKIP_LIMIT);
    stat_o.cell_occ    = rd_q.occ;
    stat_o.owner_match = rd_q.occ && (rd_q.owner == ticket_q);
    stat_o.gap_cover   = (rd_q.gap >= ticket_q);
    stat_o.first_limit = (limit_q <= LIMIT_W'(1));
    stat_o.next_limit  = (taken_inc >= {1'b0, limit_q});
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Form the result
  always_comb begin
    out_data_d   = EMPTY_WORD;
    out_status_d = STAT_DONE;
    out_got_d    = 1'b0;
    case (cmd_i.res_kind)
      RES_ENQ_DONE: out_status_d = STAT_DONE;
      RES_DEQ_WORD: begin
        if (rd_q.word == EMPTY_WORD) begin
          out_status_d = STAT_NONE;
        end else begin
          out_data_d = rd_q.word;
          out_got_d  = 1'b1;
        end
      end
      RES_NONE:  out_status_d = STAT_NONE;
      RES_FULL:  out_status_d = STAT_FULL;
      RES_LIMIT: out_status_d = STAT_LIMIT;
      default:   out_status_d = STAT_LIMIT;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_got_q    <= out_got_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_got_o    = out_got_q;

endmodule

`default_nettype wire

/* rtl/trq_ctrl.sv */
// Controller: sequences clearing, enqueue skips and dequeue ticket retries.
`default_nettype none

module trq_ctrl import trq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ENQ   = 5'b00100,
    ST_DEQ0  = 5'b01000,
    ST_DEQ   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.wr_kind    = WR_NONE;
    cmd_o.rd_src     = RD_TAIL_CUR;
    cmd_o.res_kind   = RES_ENQ_DONE;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_kind = WR_CLEAR;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_ENQ) begin
            cmd_o.enq_start = 1'b1;
            cmd_o.rd_en     = 1'b1;
            cmd_o.rd_src    = RD_TAIL_CUR;
            state_d         = ST_ENQ;
          end else begin
            state_d = ST_DEQ0;
          end
        end
      end
      ST_ENQ: begin
        if (stat_i.tail_sat) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_LIMIT;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.skip_full) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_FULL;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.cell_occ) begin
          // mark the occupied cell and walk on
          cmd_o.wr_kind  = WR_GAP;
          cmd_o.tail_inc = 1'b1;
          cmd_o.skip_inc = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_TAIL_NEXT;
        end else if (stat_i.out_free) begin
          cmd_o.wr_kind  = WR_STORE;
          cmd_o.tail_inc = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.res_kind = RES_ENQ_DONE;
          state_d        = ST_IDLE;
        end
      end
      ST_DEQ0: begin
        if (stat_i.head_sat) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_LIMIT;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.first_limit) begin
          // the first ticket is consumed but not examined
          if (stat_i.out_free) begin
            cmd_o.head_inc = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_LIMIT;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.take_en    = 1'b1;
          cmd_o.take_first = 1'b1;
          cmd_o.head_inc   = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_src     = RD_HEAD_CUR;
          state_d          = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (stat_i.owner_match) begin
          if (stat_i.out_free) begin
            cmd_o.wr_kind  = WR_EMPTY;
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_DEQ_WORD;
            state_d        = ST_IDLE;
          end
        end else if (!stat_i.gap_cover) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_NONE;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.head_sat) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_LIMIT;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.next_limit) begin
          // last ticket taken is not examined
          if (stat_i.out_free) begin
            cmd_o.take_en  = 1'b1;
            cmd_o.head_inc = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.res_kind = RES_LIMIT;
            state_d        = ST_IDLE;
          end
        end else begin
          // gap hit: take the next ticket
          cmd_o.take_en  = 1'b1;
          cmd_o.head_inc = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_HEAD_CUR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/ticket_ring_queue_with_gaps_core.sv */
// Top level of the ticket ring queue with gap marks.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata value, tuser action
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata data_out, tuser status, got_item
//  cfg       in         cfg_we_i                     cfg_wdata_i retry_limit
//
// Enqueue: the tail cell is read on accept; each occupied cell adds one more read as it is skipped.
// Dequeue: a head ticket is taken after accept, plus one more take per gap retry; each step
// is one read of the cell memory followed by a decision on its data.
// After reset a clearing pass writes all QUEUE_DEPTH cells with
// s_axis_tready low; cfg writes are taken throughout.
// A result waits in the output register while the next request is accepted; the
// following request stalls on its final step until that register is free.
`default_nettype none

module ticket_ring_queue_with_gaps_core import trq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WORD_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic [0:0]          s_axis_tuser,   // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [WORD_W-1:0]   m_axis_tdata,   // [31:0] data_out
  output logic [2:0]          m_axis_tuser    // [1:0] status, [2] got_item
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [STAT_W-1:0]   out_status;
  logic                out_got;

  trq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_status_o (out_status),
    .out_got_o    (out_got)
  );

  assign m_axis_tuser = {out_got, out_status};

endmodule

`default_nettype wire

/* rtl/trq_checker.sv */
// Port-level checker for the ticket ring queue, bound to the top level.
`default_nettype none

module trq_checker import trq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [WORD_W-1:0]   m_axis_tdata,
  input  logic [2:0]          m_axis_tuser
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // At most one result waiting and one request at work
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more requests outstanding than the block can hold");

  // No result without an outstanding request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result shown with no request outstanding");

  // No new request while one waits and another is at work
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd2 |-> !s_axis_tready)
    else $error("request accepted while both stages are busy");

  // A delivered word always reports done and is never the empty word
  a_got_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[1:0] == STAT_DONE && m_axis_tdata != EMPTY_WORD)
    else $error("got_item set on a failed or empty result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind ticket_ring_queue_with_gaps_core trq_checker u_trq_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the ticket ring queue: directed and random requests checked against a ring predictor.
`default_nettype none

module testbench;
  import trq_pkg::*;

  localparam logic [31:0]     OWNER_EMPTY   = 32'hFFFF_FFFF;
  localparam int              STALL_LIMIT   = 8000;
  localparam int              SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic              got;
  } ring_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata  = '0;  // [31:0] value
  logic [0:0]          s_axis_tuser  = '0;  // [0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [WORD_W-1:0]   m_axis_tdata;        // [31:0] data_out
  logic [2:0]          m_axis_tuser;        // [1:0] status, [2] got_item

  // Predicted ring contents and counters
  logic [31:0]         ring_owner [QUEUE_DEPTH];
  logic [31:0]         ring_gap   [QUEUE_DEPTH];
  logic [31:0]         ring_word  [QUEUE_DEPTH];
  logic [31:0]         head_tk;
  logic [31:0]         tail_tk;
  logic [LIMIT_W-1:0]  retry_lim;

  ring_result_t        pending_results [$];
  int                  mismatches      = 0;
  int                  n_enq           = 0;
  int                  n_deq           = 0;
  int                  full_count      = 0;
  int                  gap_retries     = 0;
  int                  stat_seen [4]   = '{0, 0, 0, 0};
  int                  quiet_cycles    = 0;
  int                  hold_off_cycles = 0;
  bit                  sender_idle     = 1'b1;
  bit                  sink_idle       = 1'b1;

  ticket_ring_queue_with_gaps_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic ring_result_t make_result(logic [31:0] d, logic [1:0] s, logic g);
    ring_result_t r;
    r.data   = d;
    r.status = s;
    r.got    = g;
    return r;
  endfunction

  // Store at the tail cell, marking and skipping occupied cells on the way
  function automatic ring_result_t ring_enqueue(input logic [31:0] value);
    ring_result_t res;
    int unsigned  skipped;
    int unsigned  pos;
    logic         done;
    skipped = 0;
    done    = 1'b0;
    while (!done) begin
      if (tail_tk >= {1'b0, TICKET_MAX}) begin
        res  = make_result(EMPTY_WORD, STAT_LIMIT, 1'b0);
        done = 1'b1;
      end else if (skipped >= QUEUE_DEPTH) begin
        res  = make_result(EMPTY_WORD, STAT_FULL, 1'b0);
        full_count++;
        done = 1'b1;
      end else begin
        pos = tail_tk % QUEUE_DEPTH;
        if (!ring_owner[pos][31]) begin
          ring_gap[pos] = tail_tk;
          tail_tk++;
          skipped++;
        end else begin
          ring_word[pos]  = value;
          ring_owner[pos] = tail_tk;
          tail_tk++;
          res  = make_result(EMPTY_WORD, STAT_DONE, 1'b0);
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Take head tickets until a cell matches, a gap ends or the ticket budget runs out
  function automatic ring_result_t ring_dequeue();
    ring_result_t res;
    logic [31:0]  ticket;
    logic [31:0]  word;
    int unsigned  taken;
    int unsigned  pos;
    logic         done;
    if (head_tk >= {1'b0, TICKET_MAX}) begin
      return make_result(EMPTY_WORD, STAT_LIMIT, 1'b0);
    end
    ticket = head_tk;
    head_tk++;
    taken = 1;
    done  = 1'b0;
    while (!done) begin
      pos = ticket % QUEUE_DEPTH;
      if (taken >= retry_lim) begin
        res  = make_result(EMPTY_WORD, STAT_LIMIT, 1'b0);
        done = 1'b1;
      end else if (ring_owner[pos] == ticket) begin
        word            = ring_word[pos];
        ring_owner[pos] = OWNER_EMPTY;
        if (word == EMPTY_WORD) begin
          res = make_result(EMPTY_WORD, STAT_NONE, 1'b0);
        end else begin
          res = make_result(word, STAT_DONE, 1'b1);
        end
        done = 1'b1;
      end else if (ring_gap[pos][31] || ring_gap[pos] < ticket) begin
        res  = make_result(EMPTY_WORD, STAT_NONE, 1'b0);
        done = 1'b1;
      end else if (head_tk >= {1'b0, TICKET_MAX}) begin
        res  = make_result(EMPTY_WORD, STAT_LIMIT, 1'b0);
        done = 1'b1;
      end else begin
        ticket = head_tk;
        head_tk++;
        taken++;
        gap_retries++;
      end
    end
    return res;
  endfunction

  // Favor boundary words, otherwise any 32-bit pattern
  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return EMPTY_WORD;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and record its predicted result once accepted
  task automatic send_request(input logic act, input logic [31:0] value);
    int gap;
    gap = sender_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ACT_ENQ) begin
      pending_results.push_back(ring_enqueue(value));
      n_enq++;
    end else begin
      pending_results.push_back(ring_dequeue());
      n_deq++;
    end
  endtask

  // Drop valid, drain all results, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_retry_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    retry_lim    = value;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR %0t: %s expected %h got %h", $time, what, want, seen);
    end
  endtask

  // Boundary words in FIFO order, a -1 word, empty dequeues and a stale cell
  task automatic test_basic_fifo();
    send_request(ACT_DEQ, 32'hFFFF_FFFF);
    send_request(ACT_ENQ, 32'h0000_0000);
    send_request(ACT_ENQ, 32'h7FFF_FFFF);
    send_request(ACT_ENQ, 32'h8000_0000);
    send_request(ACT_ENQ, EMPTY_WORD);
    send_request(ACT_ENQ, 32'h5555_5555);
    send_request(ACT_ENQ, 32'hAAAA_AAAA);
    repeat (6) send_request(ACT_DEQ, 32'h0000_0000);
  endtask

  // A limit of one burns a ticket per dequeue and always reports the limit
  task automatic test_retry_limit_one();
    write_retry_limit(4'd1);
    send_request(ACT_ENQ, 32'h1234_5678);
    send_request(ACT_DEQ, 32'h0000_0000);
    send_request(ACT_DEQ, 32'hFFFF_FFFF);
    send_request(ACT_ENQ, 32'hCAFE_0001);
  endtask

  // Stretches of mixed traffic, including dequeue-ahead runs that leave stale cells
  task automatic test_random_traffic(input int n_items);
    logic [LIMIT_W-1:0] limits [4];
    int                 sent;
    int                 len;
    int                 style;
    int                 k;
    logic               act;
    limits = '{4'd15, 4'd2, 4'd7, 4'd10};
    for (int phase = 0; phase < 4; phase++) begin
      write_retry_limit(limits[phase]);
      sent = 0;
      while (sent < n_items / 4) begin
        len         = $urandom_range(4, 40);
        style       = $urandom_range(0, 4);
        sender_idle = ($urandom_range(0, 3) != 0);
        sink_idle   = ($urandom_range(0, 3) != 0);
        if (style == 4) begin
          k = $urandom_range(1, 12);
          repeat (k) send_request(ACT_DEQ, draw_word());
          repeat (k) send_request(ACT_ENQ, draw_word());
          sent += 2 * k;
        end else begin
          for (int i = 0; i < len; i++) begin
            case (style)
              0:       act = 1'($urandom_range(0, 1));
              1:       act = ($urandom_range(0, 6) == 0) ? ACT_DEQ : ACT_ENQ;
              2:       act = ($urandom_range(0, 6) == 0) ? ACT_ENQ : ACT_DEQ;
              default: act = i[0] ? ACT_DEQ : ACT_ENQ;
            endcase
            send_request(act, draw_word());
            sent++;
          end
        end
      end
    end
  endtask

  // Hold the result side off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    sender_idle     = 1'b0;
    sink_idle       = 1'b0;
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i == 20) sender_idle = 1'b1;
      send_request(i[1] ? ACT_DEQ : ACT_ENQ, draw_word());
    end
    sink_idle = 1'b1;
  endtask

  // Past one lap, mix traffic so enqueues skip marked cells and dequeues retry over gaps
  task automatic test_ring_wrap(input int n_items);
    write_retry_limit(4'd15);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        sender_idle = ($urandom_range(0, 3) != 0);
        sink_idle   = ($urandom_range(0, 3) != 0);
      end
      send_request(($urandom_range(0, 2) == 0) ? ACT_ENQ : ACT_DEQ, draw_word());
    end
  endtask

  // Enqueue until the ring reports full, then walk dequeues over gap marks
  task automatic test_ring_full();
    int sent;
    int full_base;
    write_retry_limit(4'd10);
    sender_idle = 1'b0;
    sink_idle   = 1'b1;
    sent        = 0;
    full_base   = full_count;
    while (full_count < full_base + 3 && sent < 2 * QUEUE_DEPTH) begin
      send_request(ACT_ENQ, draw_word());
      sent++;
    end
    sender_idle = 1'b1;
    write_retry_limit(4'd15);
    repeat (3) send_request(ACT_DEQ, draw_word());
    write_retry_limit(4'd1);
    repeat (2) send_request(ACT_DEQ, draw_word());
  endtask

  // Reset the predictor, release reset and run the tests in turn
  initial begin : test_sequence
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ring_owner[i] = OWNER_EMPTY;
      ring_gap[i]   = '0;
      ring_word[i]  = '0;
    end
    head_tk   = '0;
    tail_tk   = '0;
    retry_lim = RETRY_LIMIT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_fifo();
    test_retry_limit_one();
    test_random_traffic(200);
    test_output_backpressure();
    test_ring_full();
    test_ring_wrap(100);
    wait_idle();

    $display("Ran %0d requests (%0d enqueue, %0d dequeue), retry limits 1, 2, 7, 10, 15",
             n_enq + n_deq, n_enq, n_deq);
    $display("Results: %0d done, %0d none, %0d full, %0d limit; %0d gap retries",
             stat_seen[STAT_DONE], stat_seen[STAT_NONE], stat_seen[STAT_FULL],
             stat_seen[STAT_LIMIT], gap_retries);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Accept results with random stalls and an occasional long hold
  initial begin : result_sink
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready) && hold_off_cycles == 0) @(posedge clk_i);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    ring_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stat_seen[m_axis_tuser[1:0]]++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, tdata", '0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data) note_mismatch("data_out", want.data, m_axis_tdata);
        if (m_axis_tuser[1:0] !== want.status) begin
          note_mismatch("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
        end
        if (m_axis_tuser[2] !== want.got) begin
          note_mismatch("got_item", 32'(want.got), 32'(m_axis_tuser[2]));
        end
      end
    end
  end

  // End the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/trq_pkg.sv
rtl/trq_dp.sv
rtl/trq_ctrl.sv
rtl/ticket_ring_queue_with_gaps_core.sv
rtl/trq_checker.sv
tb/testbench.sv
